// ----- rtl/servo_pwm_ramp_generator_assert.svh -----
// assertion macros shared by the servo ramp modules
`ifndef SERVO_PWM_RAMP_GENERATOR_ASSERT_SVH
`define SERVO_PWM_RAMP_GENERATOR_ASSERT_SVH
`ifndef SYNTH
`define SPR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SPR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SPR_ASSERT_IMP(label, ante, cons, msg)
`define SPR_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ----- rtl/spr_pkg.sv -----
package spr_pkg;

  localparam int DUTY_BITS_DEF = 15;

  localparam int ANGLE_W   = 13;
  localparam int DUTY_W    = 15;
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 3;
  localparam int SPAN_W    = 9;
  localparam int STEPS_W   = 8;
  localparam int TICK_W    = 10;
  localparam int MAG_W     = 14;
  localparam int NUM_W     = DUTY_W + MAG_W;
  localparam int DIV_W     = NUM_W + 1;
  localparam int DIVR_W    = SPAN_W + 5;
  localparam int DELTA_W   = 16;
  localparam int WIDE_W    = ANGLE_W + 2;

  localparam logic [SPAN_W-1:0]  ROT_SPAN_RST   = 9'd180;
  localparam logic [DUTY_W-1:0]  DUTY_SPAN_RST  = 15'd3277;
  localparam logic [STEPS_W-1:0] RAMP_STEPS_RST = 8'd75;
  localparam logic [TICK_W-1:0]  REST_TICKS_RST = 10'd50;
  localparam logic [DUTY_W-1:0]  START_DUTY_RST = 15'd819;

  // 180 degrees in 1/16 degree, and the half degree dead band
  localparam logic signed [WIDE_W-1:0] ANGLE_FULL = 15'sd2880;
  localparam logic [MAG_W-1:0]         MIN_MOVE   = 14'd8;
  localparam logic [DUTY_W-1:0]        MAG_MAX    = 15'd32767;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_SPAN   = 3'd0,
    REG_DUTY_SPAN  = 3'd1,
    REG_RAMP_STEPS = 3'd2,
    REG_REST_TICKS = 3'd3,
    REG_MIRROR     = 3'd4,
    REG_START_DUTY = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic mul;
    logic div_start;
    logic div_sel;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic go_div;
    logic div_done;
  } dp_stat_t;

endpackage

// ----- rtl/spr_div.sv -----
module spr_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [spr_pkg::DIV_W-1:0]  dividend,
  input  logic [spr_pkg::DIVR_W-1:0] divisor,
  output logic [spr_pkg::DIV_W-1:0]  quotient,
  output logic                      done
);
  import spr_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic [DIVR_W:0]   rem_r, rem_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DIVR_W-1:0] dvs_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIVR_W:0]   rem_sh;
  logic [DIVR_W+1:0] trial;

  // restoring division, one quotient bit per cycle
  assign rem_sh = {rem_r[DIVR_W-1:0], quo_r[DIV_W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[DIVR_W+1]) begin
        rem_nxt = trial[DIVR_W:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

// ----- rtl/spr_datapath.sv -----
module spr_datapath #(
  parameter int DUTY_BITS = spr_pkg::DUTY_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [spr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spr_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic signed [spr_pkg::ANGLE_W-1:0] in_target_angle,
  input  logic                             in_run,
  input  spr_pkg::ctrl_cmd_t               cmd,
  output spr_pkg::dp_stat_t                stat,
  output logic [spr_pkg::DUTY_W-1:0]       out_duty,
  output logic                             out_duty_write,
  output logic                             out_ramping,
  output logic signed [spr_pkg::ANGLE_W-1:0] out_position
);
  import spr_pkg::*;

  `include "servo_pwm_ramp_generator_assert.svh"

  localparam int unsigned LIM_I = (DUTY_BITS >= 15) ? 32767 : ((1 << DUTY_BITS) - 1);
  localparam logic [DUTY_W-1:0] DUTY_LIM = DUTY_W'(LIM_I);

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_RAMP = 3'b010,
    PH_REST = 3'b100
  } phase_t;

  function automatic logic [DUTY_W-1:0] lim_duty(input logic [DUTY_W-1:0] v);
    return (v > DUTY_LIM) ? DUTY_LIM : v;
  endfunction

  // configuration
  logic [SPAN_W-1:0]  rot_span_r;
  logic [DUTY_W-1:0]  duty_span_r;
  logic [STEPS_W-1:0] steps_r;
  logic [TICK_W-1:0]  rest_r;
  logic               mirror_r;

  // captured transaction and evaluation results
  logic signed [ANGLE_W-1:0] tgt_r;
  logic                      run_r;
  logic signed [ANGLE_W-1:0] t_r;
  logic                      neg_r;
  logic [MAG_W-1:0]          mag_r;
  logic                      mv_r;
  logic [NUM_W-1:0]          num_r;

  // ramp state
  phase_t                    phase_r, phase_nxt;
  logic [TICK_W-1:0]         tick_r, tick_nxt;
  logic [DUTY_W-1:0]         duty_now_r, duty_now_nxt;
  logic signed [ANGLE_W-1:0] angle_r, angle_nxt;
  logic signed [DELTA_W-1:0] delta_r, delta_nxt;
  logic                      wrote;

  logic [DUTY_W-1:0]         out_duty_r;
  logic                      out_write_r;
  logic signed [ANGLE_W-1:0] out_pos_r;

  logic [SPAN_W-1:0]         span_eff;
  logic [STEPS_W-1:0]        steps_eff;
  logic signed [WIDE_W-1:0]  tgt_x, angle_x, t_full, diff;
  logic [WIDE_W-1:0]         diff_abs;
  logic [MAG_W-1:0]          mag;
  logic                      skip;
  logic                      phase_idle;

  logic [DIV_W-1:0]          div_dividend;
  logic [DIVR_W-1:0]         div_divisor;
  logic [DIV_W-1:0]          div_quo;
  logic                      div_done;

  logic [DUTY_W-1:0]         mag_sat;
  logic signed [DELTA_W-1:0] delta_new, delta_use;
  logic signed [DUTY_W+1:0]  duty_sum;
  logic [DUTY_W-1:0]         duty_step;
  logic [TICK_W-1:0]         tick_dec;

  assign span_eff  = (rot_span_r == '0) ? SPAN_W'(1) : rot_span_r;
  assign steps_eff = (steps_r == '0) ? STEPS_W'(1) : steps_r;

  // sample evaluation
  assign tgt_x      = {{(WIDE_W-ANGLE_W){tgt_r[ANGLE_W-1]}}, tgt_r};
  assign angle_x    = {{(WIDE_W-ANGLE_W){angle_r[ANGLE_W-1]}}, angle_r};
  assign t_full     = mirror_r ? (ANGLE_FULL - tgt_x) : tgt_x;
  assign diff       = t_full - angle_x;
  assign diff_abs   = diff[WIDE_W-1] ? WIDE_W'(-diff) : diff;
  assign mag        = diff_abs[MAG_W-1:0];
  assign skip       = (mag < MIN_MOVE) || (t_full > ANGLE_FULL);
  assign phase_idle = !(phase_r == PH_RAMP || phase_r == PH_REST);

  assign stat.go_div   = run_r && phase_idle && !skip;
  assign stat.div_done = div_done;

  // first pass rounds duty_span*diff/(span*16), second divides by the step count
  assign div_dividend = cmd.div_sel ? div_quo
                                    : ({num_r, 1'b0} + DIV_W'({span_eff, 4'b0000}));
  assign div_divisor  = cmd.div_sel ? DIVR_W'(steps_eff) : {span_eff, 5'b00000};

  spr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .done     (div_done)
  );

  assign mag_sat   = (div_quo > DIV_W'(MAG_MAX)) ? MAG_MAX : div_quo[DUTY_W-1:0];
  assign delta_new = neg_r ? -$signed({1'b0, mag_sat}) : $signed({1'b0, mag_sat});
  assign delta_use = mv_r ? delta_new : delta_r;
  assign duty_sum  = $signed({2'b00, duty_now_r}) + {delta_use[DELTA_W-1], delta_use};

  always_comb begin
    if (duty_sum[DUTY_W+1]) begin
      duty_step = '0;
    end else if (duty_sum[DUTY_W:0] > {1'b0, DUTY_LIM}) begin
      duty_step = DUTY_LIM;
    end else begin
      duty_step = duty_sum[DUTY_W-1:0];
    end
  end

  assign tick_dec = (tick_r == '0) ? '0 : tick_r - 1'b1;

  always_comb begin
    phase_nxt    = phase_r;
    tick_nxt     = tick_r;
    duty_now_nxt = duty_now_r;
    angle_nxt    = angle_r;
    delta_nxt    = delta_r;
    wrote        = 1'b0;
    if (!run_r) begin
      phase_nxt = PH_IDLE;
      tick_nxt  = '0;
    end else begin
      case (phase_r)
        PH_RAMP: begin
          duty_now_nxt = duty_step;
          wrote        = 1'b1;
          if (tick_dec == '0) begin
            tick_nxt  = rest_r;
            phase_nxt = (rest_r == '0) ? PH_IDLE : PH_REST;
          end else begin
            tick_nxt = tick_dec;
          end
        end
        PH_REST: begin
          tick_nxt = tick_dec;
          if (tick_dec == '0) begin
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          if (mv_r) begin
            delta_nxt    = delta_new;
            angle_nxt    = t_r;
            duty_now_nxt = duty_step;
            wrote        = 1'b1;
            if (steps_eff == STEPS_W'(1)) begin
              tick_nxt  = rest_r;
              phase_nxt = (rest_r == '0) ? PH_IDLE : PH_REST;
            end else begin
              tick_nxt  = TICK_W'(steps_eff) - 1'b1;
              phase_nxt = PH_RAMP;
            end
          end else begin
            tick_nxt  = rest_r;
            phase_nxt = (rest_r == '0) ? PH_IDLE : PH_REST;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_span_r   <= ROT_SPAN_RST;
      duty_span_r  <= DUTY_SPAN_RST;
      steps_r      <= RAMP_STEPS_RST;
      rest_r       <= REST_TICKS_RST;
      mirror_r     <= 1'b0;
      phase_r      <= PH_IDLE;
      tick_r       <= '0;
      duty_now_r   <= lim_duty(START_DUTY_RST);
      angle_r      <= '0;
      delta_r      <= '0;
    end else begin
      if (cmd.commit) begin
        phase_r    <= phase_nxt;
        tick_r     <= tick_nxt;
        duty_now_r <= duty_now_nxt;
        angle_r    <= angle_nxt;
        delta_r    <= delta_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_ROT_SPAN:   rot_span_r  <= cfg_wdata[SPAN_W-1:0];
          REG_DUTY_SPAN:  duty_span_r <= cfg_wdata[DUTY_W-1:0];
          REG_RAMP_STEPS: steps_r     <= cfg_wdata[STEPS_W-1:0];
          REG_REST_TICKS: rest_r      <= cfg_wdata[TICK_W-1:0];
          REG_MIRROR:     mirror_r    <= cfg_wdata[0];
          REG_START_DUTY: begin
            duty_now_r <= lim_duty(cfg_wdata[DUTY_W-1:0]);
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tgt_r <= in_target_angle;
      run_r <= in_run;
    end
    if (cmd.eval) begin
      t_r   <= t_full[ANGLE_W-1:0];
      neg_r <= diff[WIDE_W-1];
      mag_r <= mag;
      mv_r  <= stat.go_div;
    end
    if (cmd.mul) begin
      num_r <= {{MAG_W{1'b0}}, duty_span_r} * {{DUTY_W{1'b0}}, mag_r};
    end
    if (cmd.commit) begin
      out_duty_r  <= duty_now_nxt;
      out_write_r <= wrote;
      out_pos_r   <= angle_nxt;
    end
  end

  assign out_duty       = out_duty_r;
  assign out_duty_write = out_write_r;
  assign out_ramping    = out_write_r;
  assign out_position   = out_pos_r;

  `SPR_ASSERT_IMP(a_duty_in_range, 1'b1, duty_now_r <= DUTY_LIM, "duty above limit")
  `SPR_ASSERT_IMP(a_tick_live, phase_r == PH_RAMP || phase_r == PH_REST, tick_r != '0,
                  "ramp or rest phase with empty tick count")
  `SPR_ASSERT_IMP(a_phase_onehot, 1'b1, $onehot(phase_r), "phase code not one-hot")

endmodule

// ----- rtl/spr_ctrl.sv -----
module spr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  spr_pkg::dp_stat_t   stat,
  output spr_pkg::ctrl_cmd_t  cmd
);
  import spr_pkg::*;

  `include "servo_pwm_ramp_generator_assert.svh"

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_EVAL  = 8'b00000010,
    S_MUL   = 8'b00000100,
    S_DIV1  = 8'b00001000,
    S_WAIT1 = 8'b00010000,
    S_DIV2  = 8'b00100000,
    S_WAIT2 = 8'b01000000,
    S_EMIT  = 8'b10000000
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = stat.go_div ? S_MUL : S_EMIT;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV1;
      end
      S_DIV1: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_WAIT1;
      end
      S_WAIT1: begin
        if (stat.div_done) begin
          state_nxt = S_DIV2;
        end
      end
      S_DIV2: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
        state_nxt     = S_WAIT2;
      end
      S_WAIT2: begin
        if (stat.div_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `SPR_ASSERT_IMP(a_commit_slot, cmd.commit, !out_valid_r || out_ready,
                  "result committed over a pending transaction")
  `SPR_ASSERT_NXT(a_result_follows, cmd.commit, out_valid_r && state_r == S_IDLE,
                  "commit did not present a result")
  `SPR_ASSERT_IMP(a_div_done_wait, stat.div_done, state_r == S_WAIT1 || state_r == S_WAIT2,
                  "divider finished outside a wait state")

endmodule

// ----- rtl/servo_pwm_ramp_generator.sv -----
// Servo PWM duty ramp generator. Every input transaction is one update tick and
// yields exactly one result transaction carrying the current duty, a write flag
// (also shown as ramping) and the last accepted target angle. A tick during a
// ramp, a rest, an idle sample that skips the move, or with run low is captured,
// evaluated and emitted before the next ready. A sample that starts a move also
// takes a multiply and two passes of a shared bit-serial divider (start, 30
// quotient bits, done): the rounded duty distance, then its division by the step
// count. The result sits in an output register, so the next tick is taken while
// it waits; a second result stalls until the first one is accepted. The user
// must write configuration registers via cfg_we/cfg_index/cfg_wdata only while
// no tick is in flight (unenforced); writing start_duty loads the duty at once.
module servo_pwm_ramp_generator #(
  parameter int DUTY_BITS = spr_pkg::DUTY_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [spr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [spr_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [spr_pkg::ANGLE_W-1:0] in_target_angle,
  input  logic                               in_run,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [spr_pkg::DUTY_W-1:0]         out_duty,
  output logic                               out_duty_write,
  output logic                               out_ramping,
  output logic signed [spr_pkg::ANGLE_W-1:0] out_position
);
  import spr_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  spr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  spr_datapath #(
    .DUTY_BITS (DUTY_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_target_angle (in_target_angle),
    .in_run          (in_run),
    .cmd             (cmd),
    .stat            (stat),
    .out_duty        (out_duty),
    .out_duty_write  (out_duty_write),
    .out_ramping     (out_ramping),
    .out_position    (out_position)
  );

endmodule
